// File: rtl/cbng_pkg.sv
// shared types and constants for the cbow negative-sample gradient block
package cbng_pkg;

    localparam int VAL_W   = 16;
    localparam int SUM_W   = 22;
    localparam int RATE_W  = 16;
    localparam int DIMS_W  = 7;
    localparam int DIM_W   = 6;
    localparam int KIND_W  = 2;
    localparam int DOT_W   = 45;
    localparam int PRED_W  = 17;
    localparam int G_W     = 34;
    localparam int PROD_W  = 56;
    localparam int CFG_IDX_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CTX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TGT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd1638;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;

    // sigmoid window edge, 6.0 in q.24
    localparam logic signed [DOT_W-1:0] SIX_Q24 = 45'sd100663296;

    // one queued item
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [DIM_W-1:0]        dim;
        logic signed [VAL_W-1:0] value;
        logic                    label;
    } t_item;

    // queue head as seen by the engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// File: rtl/cbng_front.sv
// input side: accepts items, drops ones with no effect, queues the rest
module cbng_front #(
    parameter int VEC_DIMS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cbng_pkg::KIND_W-1:0]      i_kind,
    input  logic [cbng_pkg::DIM_W-1:0]       i_dim_index,
    input  logic signed [cbng_pkg::VAL_W-1:0] i_value,
    input  logic                             i_label,
    output cbng_pkg::t_queue_head            o_head,
    input  logic                             i_pop
);

    logic            w_accept;
    logic            w_keep;
    logic            w_push;
    logic            w_load;
    cbng_pkg::t_item r_slot [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    // classify: loads outside the vector and unused kinds are dropped
    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (i_kind == cbng_pkg::KIND_CTX) || (i_kind == cbng_pkg::KIND_TGT);
    assign w_keep   = (i_kind == cbng_pkg::KIND_FIN)
                   || (w_load && ({1'b0, i_dim_index} < 7'(VEC_DIMS)));
    assign w_push   = w_accept && w_keep;

    assign o_in_ready = (r_count != 2'd2);

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= '{kind: i_kind, dim: i_dim_index,
                                  value: i_value, label: i_label};
        end
    end

    // queue pointers
    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_slot[r_rd_ptr];

endmodule

// File: rtl/cbng_back.sv
// engine: context sums, target vector, dot product, sigmoid and gradients
module cbng_back #(
    parameter int VEC_DIMS        = 64,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbng_pkg::t_queue_head              i_head,
    output logic                               o_pop,
    input  logic [cbng_pkg::RATE_W-1:0]        i_rate,
    input  logic [cbng_pkg::DIMS_W-1:0]        i_dims,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cbng_pkg::DIM_W-1:0]         o_out_dim,
    output logic signed [cbng_pkg::VAL_W-1:0]  o_target_grad,
    output logic signed [cbng_pkg::VAL_W-1:0]  o_context_grad,
    output logic                               o_last
);

    localparam int AW = (VEC_DIMS > 1) ? $clog2(VEC_DIMS) : 1;
    localparam int CW = $clog2(VEC_DIMS + 1);
    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int SW = cbng_pkg::SUM_W;
    localparam int VW = cbng_pkg::VAL_W;
    localparam int PW = cbng_pkg::PROD_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CTX_WR   = 4'd1;
    localparam logic [3:0] S_DOT      = 4'd2;
    localparam logic [3:0] S_SG1      = 4'd3;
    localparam logic [3:0] S_SG2      = 4'd4;
    localparam logic [3:0] S_SG3      = 4'd5;
    localparam logic [3:0] S_SG4      = 4'd6;
    localparam logic [3:0] S_GRD_RD   = 4'd7;
    localparam logic [3:0] S_GRD_MUL  = 4'd8;
    localparam logic [3:0] S_GRD_EMIT = 4'd9;

    logic [3:0]                 r_state;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              w_n;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              r_addr;
    logic signed [VW-1:0]       r_val;
    logic                       r_label;

    logic signed [SW-1:0]       r_sum_mem [VEC_DIMS];
    logic [VEC_DIMS-1:0]        r_sum_vld;
    logic signed [VW-1:0]       r_tgt_mem [VEC_DIMS];
    logic signed [SW-1:0]       r_sum_rd;
    logic                       r_sv_rd;
    logic signed [VW-1:0]       r_tgt_rd;
    logic signed [SW-1:0]       w_sum_eff;
    logic signed [SW:0]         w_sum_ext;
    logic signed [SW-1:0]       w_sum_sat;

    logic                       w_issue;
    logic                       r_v1;
    logic                       r_v2;
    logic signed [37:0]         r_prod;
    logic signed [cbng_pkg::DOT_W-1:0] r_acc;
    logic signed [cbng_pkg::DOT_W-1:0] w_u;
    logic [41:0]                w_p;
    logic                       r_lo;
    logic                       r_hi;
    logic [15:0]                r_q;
    logic [32:0]                w_qm;
    logic [15:0]                r_t16;
    logic [IW-1:0]              w_tidx;
    logic [cbng_pkg::PRED_W-1:0] r_pred;
    logic [cbng_pkg::PRED_W-1:0] w_rom [SIGMOID_ENTRIES];
    logic signed [17:0]         w_diff;
    logic signed [cbng_pkg::G_W-1:0] w_rate_s;
    logic signed [cbng_pkg::G_W-1:0] r_g;
    logic signed [PW-1:0]       r_tgp;
    logic signed [PW-1:0]       r_cgp;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_last;
    logic                       w_tgt_wr;

    // rounds q.44 products (q.32 step times q.12 element) to q.12 and saturates
    function automatic logic signed [15:0] f_rnd_sat(input logic signed [PW-1:0] v);
        logic signed [PW:0] b;
        logic signed [24:0] s;
        b = (PW+1)'(v) + ((PW+1)'(1) <<< 31);
        s = 25'(b >>> 32);
        if (s > 25'sd32767) begin
            return 16'sh7fff;
        end else if (s < -25'sd32768) begin
            return 16'sh8000;
        end
        return 16'(s);
    endfunction

    // sigmoid table, built at elaboration
    for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_rom
        localparam longint XQ = longint'(((64'd12 * gi) << 20) / SIGMOID_ENTRIES)
                              - (longint'(6) << 20);
        localparam longint A  = (XQ < 0) ? -XQ : XQ;
        localparam longint Y  = A * 4;
        localparam longint Y2 = (Y * Y) >>> 30;
        localparam longint Y3 = (Y2 * Y) >>> 30;
        localparam longint E0 = (longint'(1) << 30) - Y + Y2 / 2 - Y3 / 6;
        localparam longint RH = longint'(1) << 29;
        localparam longint E1 = (E0 * E0 + RH) >>> 30;
        localparam longint E2 = (E1 * E1 + RH) >>> 30;
        localparam longint E3 = (E2 * E2 + RH) >>> 30;
        localparam longint E4 = (E3 * E3 + RH) >>> 30;
        localparam longint E5 = (E4 * E4 + RH) >>> 30;
        localparam longint E6 = (E5 * E5 + RH) >>> 30;
        localparam longint E7 = (E6 * E6 + RH) >>> 30;
        localparam longint E8 = (E7 * E7 + RH) >>> 30;
        localparam longint DEN = (longint'(1) << 30) + E8;
        localparam longint POS = ((longint'(1) << 46) + DEN / 2) / DEN;
        localparam longint SIG = (XQ >= 0) ? POS : (longint'(65536) - POS);
        assign w_rom[gi] = 17'(SIG);
    end

    // dimension count clamped to 1..VEC_DIMS
    always_comb begin
        if (i_dims == '0) begin
            w_n = CW'(1);
        end else if (i_dims > 7'(VEC_DIMS)) begin
            w_n = CW'(VEC_DIMS);
        end else begin
            w_n = CW'(i_dims);
        end
    end

    assign o_pop     = (r_state == S_IDLE) && i_head.valid;
    assign w_tgt_wr  = o_pop && (i_head.item.kind == cbng_pkg::KIND_TGT);
    assign w_rd_addr = (r_state == S_IDLE) ? i_head.item.dim[AW-1:0] : r_cnt[AW-1:0];

    // memory reads, one address per cycle
    always_ff @(posedge i_clk) begin
        r_sum_rd <= r_sum_mem[w_rd_addr];
        r_sv_rd  <= r_sum_vld[w_rd_addr];
        r_tgt_rd <= r_tgt_mem[w_rd_addr];
    end

    assign w_sum_eff = r_sv_rd ? r_sum_rd : '0;

    // saturating context add
    always_comb begin
        w_sum_ext = (SW+1)'(w_sum_eff) + (SW+1)'(r_val);
        if (w_sum_ext > (SW+1)'(2097151)) begin
            w_sum_sat = SW'(2097151);
        end else if (w_sum_ext < -(SW+1)'(2097152)) begin
            w_sum_sat = -SW'(2097152);
        end else begin
            w_sum_sat = SW'(w_sum_ext);
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_CTX_WR) begin
            r_sum_mem[r_addr] <= w_sum_sat;
        end
        if (w_tgt_wr) begin
            r_tgt_mem[i_head.item.dim[AW-1:0]] <= i_head.item.value;
        end
    end

    // sum valid bits, all dropped after the last gradient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
        end else if (w_emit && w_last) begin
            r_sum_vld <= '0;
        end else if (r_state == S_CTX_WR) begin
            r_sum_vld[r_addr] <= 1'b1;
        end
    end

    // sigmoid index arithmetic
    assign w_issue = (r_state == S_DOT) && (r_cnt < w_n);
    assign w_u     = r_acc + cbng_pkg::SIX_Q24;
    assign w_p     = 42'(w_u[27:0]) * 42'(SIGMOID_ENTRIES);
    assign w_qm    = 33'(r_q) * 33'(43691);
    assign w_tidx  = (r_t16 > 16'(SIGMOID_ENTRIES - 1)) ? IW'(SIGMOID_ENTRIES - 1)
                                                         : r_t16[IW-1:0];
    assign w_diff   = (r_label ? 18'sd65536 : 18'sd0) - signed'(18'(r_pred));
    assign w_rate_s = signed'(34'(i_rate));

    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_emit     = (r_state == S_GRD_EMIT) && w_out_free;
    assign w_last     = (r_cnt == w_n - CW'(1));

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr  <= i_head.item.dim[AW-1:0];
            r_val   <= i_head.item.value;
            r_label <= i_head.item.label;
        end
        if (o_pop && i_head.item.kind == cbng_pkg::KIND_FIN) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + cbng_pkg::DOT_W'(r_prod);
        end
        if (r_v1) begin
            r_prod <= 38'(w_sum_eff) * 38'(r_tgt_rd);
        end
        if (r_state == S_SG1) begin
            r_lo <= r_acc < -cbng_pkg::SIX_Q24;
            r_hi <= r_acc > cbng_pkg::SIX_Q24;
            r_q  <= w_p[41:26];
        end
        if (r_state == S_SG2) begin
            r_t16 <= w_qm[32:17];
        end
        if (r_state == S_SG3) begin
            if (r_lo) begin
                r_pred <= '0;
            end else if (r_hi) begin
                r_pred <= 17'd65536;
            end else begin
                r_pred <= w_rom[w_tidx];
            end
        end
        if (r_state == S_SG4) begin
            r_g <= w_rate_s * 34'(w_diff);
        end
        if (r_state == S_GRD_MUL) begin
            r_tgp <= PW'(r_g) * PW'(w_sum_eff);
            r_cgp <= PW'(r_g) * PW'(r_tgt_rd);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_out_dim      <= cbng_pkg::DIM_W'(r_cnt);
            o_target_grad  <= f_rnd_sat(r_tgp);
            o_context_grad <= f_rnd_sat(r_cgp);
            o_last         <= w_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.item.kind)
                            cbng_pkg::KIND_CTX: r_state <= S_CTX_WR;
                            cbng_pkg::KIND_FIN: begin
                                r_cnt   <= '0;
                                r_state <= S_DOT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CTX_WR: r_state <= S_IDLE;
                S_DOT: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_SG1;
                    end
                end
                S_SG1: r_state <= S_SG2;
                S_SG2: r_state <= S_SG3;
                S_SG3: r_state <= S_SG4;
                S_SG4: begin
                    r_cnt   <= '0;
                    r_state <= S_GRD_RD;
                end
                S_GRD_RD:  r_state <= S_GRD_MUL;
                S_GRD_MUL: r_state <= S_GRD_EMIT;
                S_GRD_EMIT: begin
                    if (w_emit) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_GRD_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/cbow_negative_sample_gradient_top.sv
// top level of the cbow negative-sample gradient block
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_kind i_dim_index i_value i_label
//  out      output     o_out_valid / i_out_ready o_out_dim o_target_grad o_context_grad o_last
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// context load: sum memory read at pop, then written in S_CTX_WR; target load: written at pop
// finish with n dims: dot product over n dims in S_DOT, sigmoid and step in S_SG1..S_SG4,
// then gradients per dimension through S_GRD_RD, S_GRD_MUL and S_GRD_EMIT
// a two-entry queue sits between the input side and the engine
// reset is synchronous, active low; it zeroes the context sums via valid bits
// a stalled output holds the engine in its emit step only
module cbow_negative_sample_gradient_top #(
    parameter int VEC_DIMS        = 64,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [cbng_pkg::KIND_W-1:0]           i_kind,
    input  logic [cbng_pkg::DIM_W-1:0]            i_dim_index,
    input  logic signed [cbng_pkg::VAL_W-1:0]     i_value,
    input  logic                                  i_label,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [cbng_pkg::DIM_W-1:0]            o_out_dim,
    output logic signed [cbng_pkg::VAL_W-1:0]     o_target_grad,
    output logic signed [cbng_pkg::VAL_W-1:0]     o_context_grad,
    output logic                                  o_last,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cbng_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cbng_pkg::RATE_W-1:0]           i_cfg_data
);

    cbng_pkg::t_queue_head       w_head;
    logic                        w_pop;
    logic [cbng_pkg::RATE_W-1:0] r_rate;
    logic [cbng_pkg::DIMS_W-1:0] r_dims;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= cbng_pkg::RATE_RESET;
            r_dims <= cbng_pkg::DIMS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cbng_pkg::CFG_RATE: r_rate <= i_cfg_data;
                cbng_pkg::CFG_DIMS: r_dims <= i_cfg_data[cbng_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    cbng_front #(
        .VEC_DIMS (VEC_DIMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_dim_index (i_dim_index),
        .i_value     (i_value),
        .i_label     (i_label),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    cbng_back #(
        .VEC_DIMS        (VEC_DIMS),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_rate         (r_rate),
        .i_dims         (r_dims),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_dim      (o_out_dim),
        .o_target_grad  (o_target_grad),
        .o_context_grad (o_context_grad),
        .o_last         (o_last)
    );

endmodule

// File: rtl/cbng_checker.sv
// port-level checks for the cbow negative-sample gradient block
module cbng_checker #(
    parameter int VEC_DIMS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_out_dim,
    input logic [15:0] o_target_grad,
    input logic [15:0] o_context_grad,
    input logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_dim)
            && $stable(o_target_grad) && $stable(o_context_grad) && $stable(o_last))
        else $error("output changed while stalled");

    // reset leaves no result pending
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a run always ends by the last dimension
    a_last_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (7'(o_out_dim) + 7'd1) < 7'(VEC_DIMS))
        else $error("run passed the last dimension without last");

    // the final dimension always carries last
    a_top_dim_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (7'(o_out_dim) == 7'(VEC_DIMS - 1)) |-> o_last)
        else $error("top dimension without last");

endmodule

bind cbow_negative_sample_gradient_top cbng_checker #(
    .VEC_DIMS (VEC_DIMS)
) u_cbng_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_dim      (o_out_dim),
    .o_target_grad  (o_target_grad),
    .o_context_grad (o_context_grad),
    .o_last         (o_last)
);

// File: tb/sv/cbow_negative_sample_gradient_top_test.sv
// testbench for the cbow negative-sample gradient block: table and random items against a predictor
module cbow_negative_sample_gradient_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW = cbng_pkg::KIND_W;
    localparam int DW = cbng_pkg::DIM_W;
    localparam int VW = cbng_pkg::VAL_W;
    localparam int RW = cbng_pkg::RATE_W;
    localparam int N_DIMS = 64;
    localparam int N_SIG = 1024;
    localparam int ITEM_GOAL = 330;
    localparam int QUIET_FROM = 285;
    localparam int TABLE_DIMS = 4;
    localparam int DRAIN_CYCLES = 4 * N_DIMS + 40;
    localparam logic [KW-1:0] KIND_UNUSED = 2'd3;
    localparam longint SUM_HI = 2097151;
    localparam longint SUM_LO = -2097152;
    localparam longint SIX_DOT = longint'(6) <<< 24;

    // one gradient pair as it should leave the block
    typedef struct {
        logic [DW-1:0] dim;
        logic signed [VW-1:0] tgrad;
        logic signed [VW-1:0] cgrad;
        logic last;
    } t_grad_pair;

    // one row of the directed table
    typedef struct {
        logic [KW-1:0] kind;
        logic [DW-1:0] dim;
        logic signed [VW-1:0] value;
        logic label;
        bit typed;
        logic signed [VW-1:0] tgrad0;
        logic signed [VW-1:0] cgrad0;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [KW-1:0] i_kind = '0;
    logic [DW-1:0] i_dim_index = '0;
    logic signed [VW-1:0] i_value = '0;
    logic i_label = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [DW-1:0] o_out_dim;
    logic signed [VW-1:0] o_target_grad;
    logic signed [VW-1:0] o_context_grad;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [cbng_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RW-1:0] i_cfg_data = '0;

    // predictor state
    longint sig_lut [N_SIG];
    longint ctx_sums [N_DIMS];
    longint tgt_vec [N_DIMS];
    bit tgt_loaded [N_DIMS];
    longint rate_reg;
    int dims_reg;
    t_grad_pair grad_queue [$];

    int errors = 0;
    int items_sent = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    cbow_negative_sample_gradient_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_kind(i_kind), .i_dim_index(i_dim_index), .i_value(i_value), .i_label(i_label),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_dim(o_out_dim), .o_target_grad(o_target_grad),
        .o_context_grad(o_context_grad), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // overall limit
    initial begin
        #6ms;
        $display("Verification failed");
        $finish;
    end

    // sigmoid lookup built the same way as the hardware table
    function automatic void build_sigmoid();
        longint unsigned one_q30, a, y, y2, y3, e, den, pos;
        longint xq;
        one_q30 = 64'd1 << 30;
        for (int i = 0; i < N_SIG; i++) begin
            xq = longint'(((64'd12 * i) << 20) / N_SIG) - (longint'(6) <<< 20);
            a = (xq < 0) ? -xq : xq;
            y = a * 4;
            y2 = (y * y) >> 30;
            y3 = (y2 * y) >> 30;
            e = one_q30 - y + y2 / 2 - y3 / 6;
            for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 29)) >> 30;
            den = one_q30 + e;
            pos = ((one_q30 << 16) + den / 2) / den;
            sig_lut[i] = (xq >= 0) ? longint'(pos) : 65536 - longint'(pos);
        end
    endfunction

    // gradient product rounded half up to q.12 and saturated
    function automatic logic signed [VW-1:0] scale_grad(longint g, longint elem);
        longint r;
        r = (g * elem + (longint'(1) <<< 31)) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[VW-1:0];
    endfunction

    // apply one accepted item, queue the gradient pairs a finish produces
    function automatic void apply_item(logic [KW-1:0] kind, logic [DW-1:0] dim,
                                       logic signed [VW-1:0] value, logic label);
        longint dot, pred, g, s, t;
        int n;
        t_grad_pair p;
        dot = 0;
        if (kind == cbng_pkg::KIND_CTX) begin
            s = ctx_sums[dim] + longint'(value);
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            ctx_sums[dim] = s;
        end else if (kind == cbng_pkg::KIND_TGT) begin
            tgt_vec[dim] = longint'(value);
            tgt_loaded[dim] = 1'b1;
        end else if (kind == cbng_pkg::KIND_FIN) begin
            n = (dims_reg < 1) ? 1 : (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
            for (int d = 0; d < n; d++) dot += ctx_sums[d] * tgt_vec[d];
            if (dot < -SIX_DOT) pred = 0;
            else if (dot > SIX_DOT) pred = 65536;
            else begin
                t = ((dot + SIX_DOT) * N_SIG) / (longint'(12) <<< 24);
                if (t > N_SIG - 1) t = N_SIG - 1;
                pred = sig_lut[t];
            end
            g = rate_reg * (longint'(label) * 65536 - pred);
            for (int d = 0; d < n; d++) begin
                p.dim = DW'(d);
                p.tgrad = scale_grad(g, ctx_sums[d]);
                p.cgrad = scale_grad(g, tgt_vec[d]);
                p.last = (d == n - 1);
                grad_queue.insert(grad_queue.size(), p);
            end
            for (int d = 0; d < N_DIMS; d++) ctx_sums[d] = 0;
        end
    endfunction

    // present one item and hold it until accepted, with random gaps before it
    task automatic send_item(logic [KW-1:0] kind, logic [DW-1:0] dim,
                             logic signed [VW-1:0] value, logic label);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind = kind;
        i_dim_index = dim;
        i_value = value;
        i_label = label;
        do @(posedge i_clk); while (!o_in_ready);
        apply_item(kind, dim, value, label);
        items_sent++;
    endtask

    // wait until the block has drained, then settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (grad_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [cbng_pkg::CFG_IDX_W-1:0] idx, logic [RW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == cbng_pkg::CFG_RATE) rate_reg = longint'(data);
        else if (idx == cbng_pkg::CFG_DIMS) dims_reg = int'(data[cbng_pkg::DIMS_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // random element value, extremes now and then
    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return VW'($urandom_range(0, 65535));
        endcase
    endfunction

    // one well-formed sample: contexts, target, finish, with some noise
    task automatic run_sample();
        int n, nctx, dsat;
        logic signed [VW-1:0] ext;
        n = (dims_reg < 1) ? 1 : (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
        nctx = $urandom_range(1, (n > 16) ? 1 : 3);
        // occasional pile-up that drives one context sum into saturation
        if ($urandom_range(0, 9) == 0) begin
            dsat = $urandom_range(0, n - 1);
            ext = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            repeat ($urandom_range(66, 70))
                send_item(cbng_pkg::KIND_CTX, DW'(dsat), ext, 1'($urandom_range(0, 1)));
        end
        for (int c = 0; c < nctx; c++)
            for (int d = 0; d < n; d++)
                send_item(cbng_pkg::KIND_CTX, DW'(d), rand_value(), 1'($urandom_range(0, 1)));
        for (int d = 0; d < n; d++)
            if (!tgt_loaded[d] || $urandom_range(0, 1))
                send_item(cbng_pkg::KIND_TGT, DW'(d), rand_value(), 1'($urandom_range(0, 1)));
        // noise: unused kind or a stray load anywhere
        if ($urandom_range(0, 3) == 0)
            send_item($urandom_range(0, 1) ? KIND_UNUSED : KW'($urandom_range(0, 1)),
                      DW'($urandom_range(0, 63)), rand_value(), 1'($urandom_range(0, 1)));
        send_item(cbng_pkg::KIND_FIN, DW'($urandom_range(0, 63)), rand_value(),
                  1'($urandom_range(0, 1)));
    endtask

    // output side: random stall bursts, none in the quiet tail
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else if (!quiet && i_rst_n && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // compare each gradient pair with the oldest expected one
    always @(posedge i_clk) begin
        t_grad_pair e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grad_queue.size() == 0) begin
                $display("%0t: unexpected pair dim=%0d tg=%0d cg=%0d last=%0d", $realtime,
                         o_out_dim, o_target_grad, o_context_grad, o_last);
                errors++;
            end else begin
                e = grad_queue.pop_front();
                if (o_out_dim !== e.dim) begin
                    $display("%0t: out_dim expected %0d actual %0d", $realtime, e.dim, o_out_dim);
                    errors++;
                end
                if (o_target_grad !== e.tgrad) begin
                    $display("%0t: target_grad expected %0d actual %0d", $realtime,
                             e.tgrad, o_target_grad);
                    errors++;
                end
                if (o_context_grad !== e.cgrad) begin
                    $display("%0t: context_grad expected %0d actual %0d", $realtime,
                             e.cgrad, o_context_grad);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $realtime, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_table_row rows [$];
        int phase;
        int n_samples;
        int first;
        rows = '{
            '{cbng_pkg::KIND_TGT, 6'd0, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_TGT, 6'd1, 16'sh8000, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_TGT, 6'd2, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_TGT, 6'd3, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
            // empty sums: pred is one half
            '{cbng_pkg::KIND_FIN, 6'd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd409},
            '{cbng_pkg::KIND_FIN, 6'd63, 16'sh7fff, 1'b0, 1'b1, 16'sd0, -16'sd409},
            '{cbng_pkg::KIND_CTX, 6'd0, 16'sh7fff, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd1, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd63, 16'sh7fff, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{KIND_UNUSED, 6'd63, -16'sd1, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_FIN, 6'd5, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd3, 16'sh8000, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd2, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_TGT, 6'd3, 16'sh8000, 1'b1, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_FIN, 6'd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd0, -16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_CTX, 6'd1, 16'sd4096, 1'b0, 1'b0, 16'sd0, 16'sd0},
            '{cbng_pkg::KIND_FIN, 6'd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0}
        };
        build_sigmoid();
        rate_reg = longint'(cbng_pkg::RATE_RESET);
        dims_reg = int'(cbng_pkg::DIMS_RESET);
        for (int d = 0; d < N_DIMS; d++) begin
            ctx_sums[d] = 0;
            tgt_vec[d] = 0;
            tgt_loaded[d] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table with four dimensions at the reset rate
        write_reg(cbng_pkg::CFG_DIMS, RW'(TABLE_DIMS));
        foreach (rows[r]) begin
            send_item(rows[r].kind, rows[r].dim, rows[r].value, rows[r].label);
            // pairs of this finish sit at the tail of the queue
            first = grad_queue.size() - TABLE_DIMS;
            if (rows[r].typed && (grad_queue[first].tgrad !== rows[r].tgrad0 ||
                                  grad_queue[first].cgrad !== rows[r].cgrad0)) begin
                $display("%0t: table row %0d expected tg=%0d cg=%0d, predicted tg=%0d cg=%0d",
                         $realtime, r, rows[r].tgrad0, rows[r].cgrad0,
                         grad_queue[first].tgrad, grad_queue[first].cgrad);
                errors++;
            end
        end

        // random phases cycling through register settings
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_drained();
            case (phase % 7)
                0: begin write_reg(cbng_pkg::CFG_RATE, 16'hffff);
                         write_reg(cbng_pkg::CFG_DIMS, 16'd1); end
                1: begin write_reg(cbng_pkg::CFG_RATE, 16'h0000);
                         write_reg(cbng_pkg::CFG_DIMS, 16'd3); end
                2: begin write_reg(cbng_pkg::CFG_RATE, RW'($urandom_range(0, 65535)));
                         write_reg(cbng_pkg::CFG_DIMS, 16'd0); end
                3: begin write_reg(cbng_pkg::CFG_RATE, RW'($urandom_range(0, 65535)));
                         write_reg(cbng_pkg::CFG_DIMS, 16'hff80 | 16'd127); end
                4: begin write_reg(cbng_pkg::CFG_RATE, RW'($urandom_range(30000, 65535)));
                         write_reg(cbng_pkg::CFG_DIMS, RW'($urandom_range(2, 6))); end
                5: begin write_reg(cbng_pkg::CFG_RATE, RW'($urandom_range(0, 65535)));
                         write_reg(cbng_pkg::CFG_DIMS, 16'd64); end
                default: begin write_reg(cbng_pkg::CFG_RATE, RW'($urandom_range(0, 65535)));
                               write_reg(cbng_pkg::CFG_DIMS, RW'($urandom_range(1, 8))); end
            endcase
            n_samples = (dims_reg > 16 || dims_reg == 0 && 1'b0) ? 1 : 5;
            repeat (n_samples) begin
                if (items_sent < ITEM_GOAL) begin
                    quiet = (items_sent >= QUIET_FROM);
                    run_sample();
                end
            end
            phase++;
        end

        // drain and report
        wait_drained();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: cbow_negative_sample_gradient_top.f
rtl/cbng_pkg.sv
rtl/cbng_front.sv
rtl/cbng_back.sv
rtl/cbow_negative_sample_gradient_top.sv
rtl/cbng_checker.sv
tb/sv/cbow_negative_sample_gradient_top_test.sv
